// ----- rtl/stbs_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted table binary search: shared package
// Field widths, operation and status codes, and the search result struct.
// ----------------------------------------------------------------------------
package stbs_pkg;

	localparam int ID_W     = 32;
	localparam int HANDLE_W = 32;
	localparam int KEY_W    = 16;
	localparam int INDEX_W  = 8;
	localparam int COUNT_W  = 9;
	localparam int ENTRY_W  = ID_W + 3 * HANDLE_W;

	typedef logic signed [ID_W-1:0]  id_t;
	typedef logic        [HANDLE_W-1:0] handle_t;
	typedef logic signed [KEY_W-1:0] key_t;
	typedef logic        [INDEX_W-1:0] index_t;
	typedef logic        [COUNT_W-1:0] count_t;

	typedef enum logic {
		OP_WRITE  = 1'b0,
		OP_LOOKUP = 1'b1
	} op_t;

	typedef enum logic {
		STATUS_OK   = 1'b0,
		STATUS_MISS = 1'b1
	} status_t;

	// One table entry as it sits in the entry memory.
	typedef struct packed {
		id_t     id;
		handle_t name;
		handle_t description;
		handle_t short_name;
	} entry_t;

	// Report from the search sequencer to the top level.
	typedef struct packed {
		logic done;
		logic hit;
	} srch_res_t;

endpackage

// ----- rtl/stbs_if.sv -----
// ----------------------------------------------------------------------------
// Sorted table binary search: channel interfaces
// Request channel (table writes and lookups) and response channel.
// ----------------------------------------------------------------------------
interface stbs_req_if;
	logic                valid;
	logic                ready;
	stbs_pkg::op_t       operation;
	stbs_pkg::index_t    entry_index;
	stbs_pkg::id_t       entry_id;
	stbs_pkg::handle_t   entry_name;
	stbs_pkg::handle_t   entry_description;
	stbs_pkg::handle_t   entry_short_name;
	stbs_pkg::key_t      search_key;

	modport source (
		output valid, operation, entry_index, entry_id, entry_name,
		       entry_description, entry_short_name, search_key,
		input  ready
	);
	modport sink (
		input  valid, operation, entry_index, entry_id, entry_name,
		       entry_description, entry_short_name, search_key,
		output ready
	);
endinterface

interface stbs_rsp_if;
	logic                valid;
	logic                ready;
	stbs_pkg::status_t   status;
	stbs_pkg::handle_t   name_handle;
	stbs_pkg::handle_t   description_handle;
	stbs_pkg::handle_t   short_name_handle;

	modport source (
		output valid, status, name_handle, description_handle, short_name_handle,
		input  ready
	);
	modport sink (
		input  valid, status, name_handle, description_handle, short_name_handle,
		output ready
	);
endinterface

// ----- rtl/stbs_ram.sv -----
// ----------------------------------------------------------------------------
// Sorted table binary search: generic RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module stbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/stbs_search.sv -----
// ----------------------------------------------------------------------------
// Sorted table binary search: search sequencer
// Walks the split rule one pivot per cycle through a single compare unit.
// ----------------------------------------------------------------------------
module stbs_search #(
	parameter int TABLE_DEPTH = 256,
	localparam int AW = $clog2(TABLE_DEPTH),
	localparam int NW = $clog2(TABLE_DEPTH + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  stbs_pkg::key_t      key,
	input  logic [NW-1:0]       count,
	input  stbs_pkg::id_t       rd_id,
	output logic                rd_en,
	output logic [AW-1:0]       rd_addr,
	output stbs_pkg::srch_res_t res
);
	import stbs_pkg::*;

	typedef enum logic [2:0] {
		SS_IDLE = 3'b001,
		SS_STEP = 3'b010,
		SS_MISS = 3'b100
	} sstate_t;

	sstate_t       state_q;
	id_t           key_q;
	logic [AW-1:0] base_q;
	logic [AW-1:0] piv_q;
	logic [NW-1:0] n_q;

	logic          eq;
	logic          gt;
	logic [NW-1:0] n_lo;
	logic [NW-1:0] n_hi;
	logic [NW-1:0] n_nxt;
	logic [AW-1:0] base_nxt;
	logic [AW-1:0] piv_nxt;
	logic [AW-1:0] piv_start;
	logic          finish;

	// The entry at piv_q arrives from the memory in this cycle.
	always_comb begin
		eq        = (rd_id == key_q);
		gt        = (key_q > rd_id);
		n_lo      = n_q >> 1;
		n_hi      = n_q - n_lo - NW'(1);
		n_nxt     = gt ? n_hi : n_lo;
		base_nxt  = gt ? AW'(piv_q + AW'(1)) : base_q;
		piv_nxt   = AW'(NW'(base_nxt) + (n_nxt >> 1));
		piv_start = AW'(count >> 1);
		finish    = eq || (n_nxt == '0);
	end

	always_comb begin
		rd_en    = 1'b0;
		rd_addr  = piv_start;
		res.done = 1'b0;
		res.hit  = 1'b0;
		unique case (state_q)
			SS_IDLE: begin
				rd_en = start && (count != '0);
			end
			SS_STEP: begin
				rd_en    = !finish;
				rd_addr  = piv_nxt;
				res.done = finish;
				res.hit  = eq;
			end
			SS_MISS: begin
				res.done = 1'b1;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SS_IDLE;
		end else begin
			unique case (state_q)
				SS_IDLE: begin
					if (start) begin
						state_q <= (count == '0) ? SS_MISS : SS_STEP;
					end
				end
				SS_STEP: begin
					if (finish) begin
						state_q <= SS_IDLE;
					end
				end
				SS_MISS: begin
					state_q <= SS_IDLE;
				end
				default: begin
					state_q <= SS_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == SS_IDLE && start) begin
			key_q  <= {{(ID_W - KEY_W){key[KEY_W-1]}}, key};
			n_q    <= count;
			base_q <= '0;
			piv_q  <= piv_start;
		end else if (state_q == SS_STEP && !finish) begin
			n_q    <= n_nxt;
			base_q <= base_nxt;
			piv_q  <= piv_nxt;
		end
	end

endmodule

// ----- rtl/sorted_table_binary_search.sv -----
// A write request is answered through ST_REPLY and the output register; a lookup
// first runs its pivot compares in ST_SEARCH (a zero count costs one step), at most
// about log2 of the searched count plus one (9 pivots for 256 entries).
// A new request is taken only after the last one has loaded its response; the
// single memory read port delivers one pivot per cycle.
// Reset clears control state and the current handles; the table is undefined.
// ----------------------------------------------------------------------------
// Sorted table binary search: top level
// Holds the entry table and current handles and answers every request.
// ----------------------------------------------------------------------------
module sorted_table_binary_search #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  stbs_pkg::count_t     cfg_wdata,
	stbs_req_if.sink             req,
	stbs_rsp_if.source           rsp
);
	import stbs_pkg::*;

	// Address width of the table and width of a count that can hold the depth.
	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int NW = $clog2(TABLE_DEPTH + 1);
	// Common width for comparing the programmed count against the depth.
	localparam int XW = (NW > COUNT_W) ? NW : COUNT_W;

	// Request-level sequencing: take a request, run it, hand the response
	// to the output register.
	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SEARCH = 3'b010,
		ST_REPLY  = 3'b100
	} state_t;

	state_t    state_q;
	count_t    entry_count_q;

	handle_t   cur_name_q;
	handle_t   cur_desc_q;
	handle_t   cur_short_q;
	status_t   status_q;

	logic      rsp_valid_q;
	status_t   rsp_status_q;
	handle_t   rsp_name_q;
	handle_t   rsp_desc_q;
	handle_t   rsp_short_q;

	logic          req_fire;
	logic          is_write;
	logic          is_lookup;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	entry_t        ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	entry_t        ram_rdata;
	logic [XW-1:0] count_x;
	logic [NW-1:0] count_sat;
	logic          rsp_load;
	srch_res_t     srch_res;

	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign is_write  = (req.operation == OP_WRITE);
	assign is_lookup = (req.operation == OP_LOOKUP);

	// A write to a slot beyond the table is dropped but still answered.
	assign ram_we    = req_fire && is_write &&
	                   ({{(32 - INDEX_W){1'b0}}, req.entry_index} < 32'(TABLE_DEPTH));
	assign ram_waddr = AW'(req.entry_index);
	assign ram_wdata = '{
		id:          req.entry_id,
		name:        req.entry_name,
		description: req.entry_description,
		short_name:  req.entry_short_name
	};

	// A programmed count above the table depth searches the whole table.
	assign count_x   = XW'(entry_count_q);
	assign count_sat = (count_x > XW'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH) : NW'(count_x);

	stbs_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// The sequencer drives the memory read port. On a hit the read register
	// still holds the matching entry, so its handles are taken from there.
	stbs_search #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_search (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (req_fire && is_lookup),
		.key     (req.search_key),
		.count   (count_sat),
		.rd_id   (ram_rdata.id),
		.rd_en   (ram_re),
		.rd_addr (ram_raddr),
		.res     (srch_res)
	);

	// The output register frees as soon as its response is taken, so a
	// finished response only waits in ST_REPLY while the slot is still full.
	assign rsp_load = (state_q == ST_REPLY) && (!rsp_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			entry_count_q <= '0;
			cur_name_q    <= '0;
			cur_desc_q    <= '0;
			cur_short_q   <= '0;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				entry_count_q <= cfg_wdata;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						state_q <= is_lookup ? ST_SEARCH : ST_REPLY;
					end
				end
				ST_SEARCH: begin
					if (srch_res.done) begin
						state_q <= ST_REPLY;
						if (srch_res.hit) begin
							cur_name_q  <= ram_rdata.name;
							cur_desc_q  <= ram_rdata.description;
							cur_short_q <= ram_rdata.short_name;
						end
					end
				end
				ST_REPLY: begin
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Response payload; the status is settled when the request is resolved.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			status_q <= STATUS_OK;
		end else if (state_q == ST_SEARCH && srch_res.done) begin
			status_q <= srch_res.hit ? STATUS_OK : STATUS_MISS;
		end
		if (rsp_load) begin
			rsp_status_q <= status_q;
			rsp_name_q   <= cur_name_q;
			rsp_desc_q   <= cur_desc_q;
			rsp_short_q  <= cur_short_q;
		end
	end

	assign rsp.valid              = rsp_valid_q;
	assign rsp.status             = rsp_status_q;
	assign rsp.name_handle        = rsp_name_q;
	assign rsp.description_handle = rsp_desc_q;
	assign rsp.short_name_handle  = rsp_short_q;

`ifndef SYNTHESIS
	// The sequencer reports completion only while a lookup is in flight.
	a_done_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		srch_res.done |-> (state_q == ST_SEARCH))
		else $error("search completion outside of a lookup");

	// An accepted lookup always moves on to the search state.
	a_lookup_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(req_fire && is_lookup) |=> (state_q == ST_SEARCH))
		else $error("accepted lookup did not start a search");

	// The table is only written by an accepted write request.
	a_write_source: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (req_fire && is_write))
		else $error("table written without a write request");

	// No memory read is issued once the response is waiting.
	a_no_read_in_reply: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_REPLY) |-> !ram_re)
		else $error("table read while a response is pending");
`endif

endmodule

// ----- tb/stbs_answer_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted table binary search: answer checker
// Watches the register port and both channels, keeps its own copy of the
// entry table and current handles, and compares every response field by field.
// ----------------------------------------------------------------------------
module stbs_answer_checker
	import stbs_pkg::*;
#(
	parameter int TABLE_DEPTH = 256
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   cfg_we,
	input  count_t cfg_wdata,
	stbs_req_if    req,
	stbs_rsp_if    rsp,
	output int     errors,
	output int     outstanding
);

	typedef struct {
		status_t status;
		handle_t name;
		handle_t description;
		handle_t short_name;
	} answer_t;

	id_t     id_mem          [TABLE_DEPTH];
	handle_t name_mem        [TABLE_DEPTH];
	handle_t description_mem [TABLE_DEPTH];
	handle_t short_name_mem  [TABLE_DEPTH];
	handle_t cur_name;
	handle_t cur_description;
	handle_t cur_short_name;
	count_t  searched_count;
	answer_t awaited_answers[$];
	int      mismatch_count;

	assign errors = mismatch_count;

	initial mismatch_count = 0;

	task automatic report_mismatch(input string field, input logic [31:0] seen,
			input logic [31:0] wanted);
		$display("%0t ns: response %s is %h, expected %h", $time, field, seen, wanted);
		mismatch_count++;
	endtask

	// Halving search over the first searched_count entries: a key above the
	// pivot goes to the upper part, any other key to the lower part.
	function automatic bit search_hit(input id_t key, output int slot);
		int base;
		int span;
		int half;
		int pivot;
		base = 0;
		span = (searched_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(searched_count);
		slot = 0;
		while (span > 0) begin
			if (span == 1) begin
				slot = base;
				return id_mem[base] == key;
			end
			half  = span / 2;
			pivot = base + half;
			if (id_mem[pivot] == key) begin
				slot = pivot;
				return 1'b1;
			end
			if (key > id_mem[pivot]) begin
				base = pivot + 1;
				span = span - half - 1;
			end else begin
				span = half;
			end
		end
		return 1'b0;
	endfunction

	function automatic answer_t predict_answer(input op_t op, input index_t idx,
			input id_t id, input handle_t nm, input handle_t ds, input handle_t sn,
			input key_t key);
		answer_t ans;
		id_t     wide_key;
		int      slot;
		ans.status = STATUS_OK;
		if (op == OP_WRITE) begin
			if (idx < TABLE_DEPTH) begin
				id_mem[idx]          = id;
				name_mem[idx]        = nm;
				description_mem[idx] = ds;
				short_name_mem[idx]  = sn;
			end
		end else begin
			wide_key = key;
			if (search_hit(wide_key, slot)) begin
				cur_name        = name_mem[slot];
				cur_description = description_mem[slot];
				cur_short_name  = short_name_mem[slot];
			end else begin
				ans.status = STATUS_MISS;
			end
		end
		ans.name        = cur_name;
		ans.description = cur_description;
		ans.short_name  = cur_short_name;
		return ans;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		answer_t want;
		if (!arst_n) begin
			cur_name        = '0;
			cur_description = '0;
			cur_short_name  = '0;
			searched_count  = '0;
			awaited_answers.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we === 1'b1)
				searched_count = cfg_wdata;
			if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
				if (awaited_answers.size() == 0) begin
					report_mismatch("with nothing awaited", {31'b0, rsp.status}, 32'b0);
				end else begin
					want = awaited_answers.pop_front();
					if (rsp.status !== want.status)
						report_mismatch("status", {31'b0, rsp.status}, {31'b0, want.status});
					if (rsp.name_handle !== want.name)
						report_mismatch("name_handle", rsp.name_handle, want.name);
					if (rsp.description_handle !== want.description)
						report_mismatch("description_handle", rsp.description_handle,
							want.description);
					if (rsp.short_name_handle !== want.short_name)
						report_mismatch("short_name_handle", rsp.short_name_handle,
							want.short_name);
				end
			end
			if (req.valid === 1'b1 && req.ready === 1'b1)
				awaited_answers.push_back(predict_answer(req.operation, req.entry_index,
					req.entry_id, req.entry_name, req.entry_description,
					req.entry_short_name, req.search_key));
			outstanding <= awaited_answers.size();
		end
	end

endmodule

// ----- tb/sorted_table_binary_search_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted table binary search: testbench top
// Drives table writes and key lookups through the request channel, moves the
// entry count between phases, and gives the verdict from the answer checker.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_test;
	import stbs_pkg::*;

	localparam int DEPTH      = 256;
	localparam int ITEM_GOAL  = 1750;
	// Extra clock edges waited after the final drain, before the verdict.
	localparam int TAIL_WAIT  = 12;

	logic   clk;
	logic   arst_n;
	logic   cfg_we;
	count_t cfg_wdata;

	stbs_req_if req ();
	stbs_rsp_if rsp ();

	int mismatch_total;
	int pending_answers;

	// Idle chances in percent, changed from phase to phase by the stimulus.
	int sender_idle_pct;
	int stall_pct;
	int requests_sent;

	// Mirror of the ids written so far, used only to aim lookups at real keys.
	id_t slot_id [DEPTH];

	sorted_table_binary_search #(
		.TABLE_DEPTH(DEPTH)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req),
		.rsp       (rsp)
	);

	stbs_answer_checker #(
		.TABLE_DEPTH(DEPTH)
	) u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.req         (req),
		.rsp         (rsp),
		.errors      (mismatch_total),
		.outstanding (pending_answers)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// The response side stalls at random with the chance of the current phase.
	initial begin
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rsp.ready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	// Hard stop in case the block hangs; far beyond the slowest correct run.
	initial begin
		#20_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Presents one request after a random idle gap and holds it until it is
	// taken. Valid is only lowered when a gap comes, so it never drops and
	// rises within the same time step.
	task automatic send_request(input op_t op, input index_t idx, input id_t id,
			input handle_t nm, input handle_t ds, input handle_t sn, input key_t key);
		int gap;
		gap = 0;
		while ($urandom_range(0, 99) < sender_idle_pct)
			gap++;
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid             <= 1'b1;
		req.operation         <= op;
		req.entry_index       <= idx;
		req.entry_id          <= id;
		req.entry_name        <= nm;
		req.entry_description <= ds;
		req.entry_short_name  <= sn;
		req.search_key        <= key;
		@(posedge clk);
		while (req.ready !== 1'b1)
			@(posedge clk);
		requests_sent++;
	endtask

	// A write carries a random key and a lookup random entry fields, since
	// the block must ignore the fields that its operation does not use.
	task automatic send_write(input index_t idx, input id_t id, input handle_t nm,
			input handle_t ds, input handle_t sn);
		slot_id[idx] = id;
		send_request(OP_WRITE, idx, id, nm, ds, sn, key_t'($urandom));
	endtask

	task automatic send_lookup(input key_t key);
		send_request(OP_LOOKUP, index_t'($urandom), id_t'($urandom), $urandom,
			$urandom, $urandom, key);
	endtask

	// Stops sending and waits until every awaited response has come back. The
	// first edge lets the checker count a request taken in this very step.
	task automatic drain();
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending_answers != 0)
			@(posedge clk);
	endtask

	// The entry count is only changed while nothing is in flight.
	task automatic set_entry_count(input count_t count);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= count;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Writes slots 0 to count-1 in ascending id order. Narrow ids stay in the
	// key range so that lookups can hit; wide ids span all 32 bits and pin the
	// two extremes at the ends of the table.
	task automatic fill_table(input int count, input bit wide);
		id_t ids[$];
		int  step;
		int  walk;
		if (wide) begin
			for (int i = 0; i < count; i++)
				ids.push_back(id_t'($urandom));
			ids.sort();
			if (count >= 2) begin
				ids[0]         = {1'b1, 31'b0};
				ids[count - 1] = {1'b0, {31{1'b1}}};
			end
		end else begin
			step = 65535 / (count + 1);
			if (step > 400)
				step = 400;
			walk = -32768 + int'($urandom_range(0, step - 1));
			for (int i = 0; i < count; i++) begin
				ids.push_back(id_t'(walk));
				walk += int'($urandom_range(1, step));
			end
		end
		for (int i = 0; i < count; i++)
			send_write(index_t'(i), ids[i], $urandom, $urandom, $urandom);
	endtask

	// Lookups over a table of count written entries: mostly keys that are in
	// the table, then keys just beside one, random keys and the key extremes.
	// A few writes land anywhere, which may leave the table unsorted.
	task automatic run_lookups(input int count, input int total);
		key_t extremes [4];
		int   pick;
		int   slot;
		key_t key;
		extremes = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff};
		for (int i = 0; i < total; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 5) begin
				send_write(index_t'($urandom), id_t'($urandom), $urandom, $urandom,
					$urandom);
			end else begin
				slot = (count > 0) ? $urandom_range(0, count - 1) : 0;
				if (count > 0 && pick < 55 && slot_id[slot] >= -32768 &&
						slot_id[slot] <= 32767)
					key = key_t'(slot_id[slot]);
				else if (count > 0 && pick < 75)
					key = $urandom_range(0, 1) ? key_t'(slot_id[slot] + 1) :
						key_t'(slot_id[slot] - 1);
				else if (pick < 90)
					key = key_t'($urandom);
				else
					key = extremes[$urandom_range(0, 3)];
				send_lookup(key);
			end
			// Now and then the sender waits until every response is back.
			if ($urandom_range(0, 99) == 0)
				drain();
		end
	endtask

	initial begin
		int   phase_no;
		int   count;
		int   searched;
		bit   wide;

		arst_n                <= 1'b0;
		cfg_we                <= 1'b0;
		cfg_wdata             <= '0;
		req.valid             <= 1'b0;
		req.operation         <= OP_WRITE;
		req.entry_index       <= '0;
		req.entry_id          <= '0;
		req.entry_name        <= '0;
		req.entry_description <= '0;
		req.entry_short_name  <= '0;
		req.search_key        <= '0;
		sender_idle_pct        = 0;
		stall_pct              = 0;
		requests_sent          = 0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. With the reset count of zero every lookup misses and
		// returns the cleared handles.
		send_lookup(16'sh8000);
		send_lookup(16'sh7fff);

		// Three sorted entries at the key extremes and zero, plus slots holding
		// the 32-bit id extremes, one of them at the last table slot.
		send_write(8'd0, 32'shffff8000, 32'hffffffff, 32'h00000000, 32'h5a5a5a5a);
		send_write(8'd1, 32'sh00000000, 32'h00000001, 32'h80000000, 32'h7fffffff);
		send_write(8'd2, 32'sh00007fff, 32'ha5a5a5a5, 32'hffffffff, 32'h00000000);
		send_write(8'd3, 32'sh80000000, 32'h12345678, 32'h9abcdef0, 32'h0f0f0f0f);
		send_write(8'd255, 32'sh7fffffff, 32'h00000000, 32'h00000000, 32'hffffffff);

		// Hits at both key extremes and zero; misses keep the last handles.
		set_entry_count(9'd3);
		send_lookup(16'sh8000);
		send_lookup(16'sh0000);
		send_lookup(16'sh7fff);
		send_lookup(16'sh0001);
		send_lookup(16'shffff);

		// A single entry is compared directly.
		set_entry_count(9'd1);
		send_lookup(16'sh0000);
		send_lookup(16'sh8000);

		// Random phases. The early ones visit the count extremes, including
		// a count above the depth that must behave as the full table, which is
		// fully written by the phase before it.
		phase_no = 0;
		while (requests_sent < ITEM_GOAL) begin
			case (phase_no % 4)
				0: begin sender_idle_pct = 0;  stall_pct = 0;  end
				1: begin sender_idle_pct = 46; stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  stall_pct = 46; end
				default: begin sender_idle_pct = 6; stall_pct = 6; end
			endcase
			case (phase_no)
				0: count = 0;
				1: count = 1;
				2: count = 2;
				3: count = 256;
				4: count = 511;
				5: count = 255;
				default: count = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 256) :
					$urandom_range(1, 40);
			endcase
			wide = ($urandom_range(0, 5) == 0);
			set_entry_count(count_t'(count));
			searched = (count > DEPTH) ? DEPTH : count;
			if (count <= DEPTH)
				fill_table(count, wide);
			run_lookups(searched, (2 * searched + 24 > 300) ? 300 : 2 * searched + 24);
			phase_no++;
		end

		drain();
		repeat (TAIL_WAIT) @(posedge clk);
		if (mismatch_total == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
